[rtl/core/u2u_pkg.sv]
`default_nettype none

package u2u_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned PtrWidth   = $clog2(QueueDepth);
  localparam int unsigned CountWidth = $clog2(QueueDepth + 1);

  localparam logic [7:0]  AsciiLimit = 8'h80;
  localparam logic [7:0]  ContMin    = 8'h80;
  localparam logic [7:0]  ContMax    = 8'hBF;
  localparam logic [7:0]  LeadMin    = 8'hC2;
  localparam logic [7:0]  Lead3Min   = 8'hE0;
  localparam logic [7:0]  Lead4Min   = 8'hF0;
  localparam logic [7:0]  LeadMax    = 8'hF4;
  localparam logic [7:0]  LeadSurr   = 8'hED;
  localparam logic [7:0]  ContE0Min  = 8'hA0;
  localparam logic [7:0]  ContF0Min  = 8'h90;
  localparam logic [7:0]  ContEdMax  = 8'h9F;
  localparam logic [7:0]  ContF4Max  = 8'h8F;

  localparam logic [15:0] HighSurrBase = 16'hD800;
  localparam logic [15:0] LowSurrBase  = 16'hDC00;
  localparam logic [20:0] SuppBase     = 21'h010000;
  localparam logic [15:0] ReplReset    = 16'hFFFD;

  // What one input byte leaves for the output side: replacement units first,
  // then up to two decoded units.
  typedef struct packed {
    logic [2:0]  n_repl;
    logic [1:0]  n_data;
    logic [15:0] unit0;
    logic [15:0] unit1;
  } run_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

[rtl/core/u2u_front.sv]
`default_nettype none

module u2u_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        end_of_string_i,
  output u2u_pkg::run_t    run_o,
  output logic             run_valid_o
);

  logic [7:0]  lead_q, lead_d;
  logic [1:0]  held_q, held_d;
  logic [1:0]  needed_q, needed_d;
  logic [20:0] partial_q, partial_d;

  logic [7:0]  lo, hi;
  logic        cont_ok;
  logic [20:0] acc;
  logic [19:0] offset;
  logic        do_lead;
  u2u_pkg::run_t run;

  always_comb begin
    lo = u2u_pkg::ContMin;
    hi = u2u_pkg::ContMax;
    if (held_q == 2'd1) begin
      if (lead_q == u2u_pkg::Lead3Min) begin
        lo = u2u_pkg::ContE0Min;
      end else if (lead_q == u2u_pkg::LeadSurr) begin
        hi = u2u_pkg::ContEdMax;
      end else if (lead_q == u2u_pkg::Lead4Min) begin
        lo = u2u_pkg::ContF0Min;
      end else if (lead_q == u2u_pkg::LeadMax) begin
        hi = u2u_pkg::ContF4Max;
      end
    end
    cont_ok = (in_byte_i >= lo) && (in_byte_i <= hi);
  end

  assign acc    = {partial_q[14:0], in_byte_i[5:0]};
  assign offset = 20'(acc - u2u_pkg::SuppBase);

  always_comb begin
    lead_d    = lead_q;
    held_d    = held_q;
    needed_d  = needed_q;
    partial_d = partial_q;
    run       = '0;
    do_lead   = 1'b0;

    if (needed_q != 2'd0) begin
      if (cont_ok) begin
        if (needed_q == 2'd1) begin
          if (acc < u2u_pkg::SuppBase) begin
            run.n_data = 2'd1;
            run.unit0  = acc[15:0];
          end else begin
            run.n_data = 2'd2;
            run.unit0  = u2u_pkg::HighSurrBase + {6'd0, offset[19:10]};
            run.unit1  = u2u_pkg::LowSurrBase + {6'd0, offset[9:0]};
          end
          lead_d    = '0;
          held_d    = '0;
          needed_d  = '0;
          partial_d = '0;
        end else if (end_of_string_i) begin
          run.n_repl = {1'b0, held_q} + 3'd1;
          lead_d     = '0;
          held_d     = '0;
          needed_d   = '0;
          partial_d  = '0;
        end else begin
          held_d    = held_q + 2'd1;
          needed_d  = needed_q - 2'd1;
          partial_d = acc;
        end
      end else begin
        run.n_repl = {1'b0, held_q};
        lead_d     = '0;
        held_d     = '0;
        needed_d   = '0;
        partial_d  = '0;
        do_lead    = 1'b1;
      end
    end else begin
      do_lead = 1'b1;
    end

    if (do_lead) begin
      if (in_byte_i < u2u_pkg::AsciiLimit) begin
        run.n_data = 2'd1;
        run.unit0  = {8'd0, in_byte_i};
      end else if ((in_byte_i >= u2u_pkg::LeadMin) && (in_byte_i <= u2u_pkg::LeadMax)) begin
        if (end_of_string_i) begin
          run.n_repl = run.n_repl + 3'd1;
        end else begin
          lead_d = in_byte_i;
          held_d = 2'd1;
          if (in_byte_i < u2u_pkg::Lead3Min) begin
            needed_d  = 2'd1;
            partial_d = {16'd0, in_byte_i[4:0]};
          end else if (in_byte_i < u2u_pkg::Lead4Min) begin
            needed_d  = 2'd2;
            partial_d = {17'd0, in_byte_i[3:0]};
          end else begin
            needed_d  = 2'd3;
            partial_d = {18'd0, in_byte_i[2:0]};
          end
        end
      end else begin
        run.n_repl = run.n_repl + 3'd1;
      end
    end
  end

  assign run_o       = run;
  assign run_valid_o = accept_i && ((run.n_repl != 3'd0) || (run.n_data != 2'd0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q    <= '0;
      held_q    <= '0;
      needed_q  <= '0;
      partial_q <= '0;
    end else if (accept_i) begin
      lead_q    <= lead_d;
      held_q    <= held_d;
      needed_q  <= needed_d;
      partial_q <= partial_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/u2u_queue.sv]
`default_nettype none

module u2u_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire u2u_pkg::run_t run_i,
  input  wire logic          pop_i,
  output u2u_pkg::run_t      run_o,
  output u2u_pkg::q_status_t status_o
);

  u2u_pkg::run_t entries_q [u2u_pkg::QueueDepth];

  logic [u2u_pkg::PtrWidth-1:0]   wr_ptr_q, rd_ptr_q;
  logic [u2u_pkg::CountWidth-1:0] count_q;

  logic do_push, do_pop;

  assign status_o.full  = (count_q == u2u_pkg::CountWidth'(u2u_pkg::QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign run_o   = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= run_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + u2u_pkg::PtrWidth'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + u2u_pkg::PtrWidth'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + u2u_pkg::CountWidth'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - u2u_pkg::CountWidth'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/u2u_back.sv]
`default_nettype none

module u2u_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_valid_i,
  input  wire logic [15:0]   cfg_data_i,
  input  wire u2u_pkg::run_t run_i,
  input  wire logic          run_avail_i,
  output logic               run_done_o,
  output logic               out_valid_o,
  input  wire logic          out_pop_i,
  output logic [15:0]        code_unit_o,
  output logic               is_replacement_o,
  output logic               last_of_run_o
);

  logic [15:0] repl_q;
  logic [1:0]  idx_q;
  logic        valid_q;
  logic [15:0] unit_q;
  logic        rep_q;
  logic        last_q;

  logic [2:0]  total;
  logic        data_idx;
  logic        is_rep;
  logic        is_last;
  logic        emit;
  logic [15:0] unit;

  assign total    = run_i.n_repl + {1'b0, run_i.n_data};
  assign data_idx = idx_q[0] ^ run_i.n_repl[0];
  assign is_rep   = ({1'b0, idx_q} < run_i.n_repl);
  assign is_last  = ({1'b0, idx_q} == (total - 3'd1));
  assign emit     = run_avail_i && (!valid_q || out_pop_i);

  always_comb begin
    if (is_rep) begin
      unit = repl_q;
    end else if (data_idx) begin
      unit = run_i.unit1;
    end else begin
      unit = run_i.unit0;
    end
  end

  assign run_done_o = emit && is_last;

  always_ff @(posedge clk_i) begin
    if (emit) begin
      unit_q <= unit;
      rep_q  <= is_rep;
      last_q <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_q  <= u2u_pkg::ReplReset;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        repl_q <= cfg_data_i;
      end
      if (emit) begin
        valid_q <= 1'b1;
        idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
      end else if (out_pop_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = valid_q;
  assign code_unit_o      = unit_q;
  assign is_replacement_o = rep_q;
  assign last_of_run_o    = last_q;

endmodule

`default_nettype wire

[rtl/core/utf8_to_utf16_transcoder.sv]
`default_nettype none

// UTF-8 to UTF-16 transcoder with strict validation. One byte is taken per
// clock cycle while full is low; the decoder works out in the same cycle what
// the byte yields and hands it to a two-entry queue. The result side sends one
// code unit per cycle from that queue if pop is high, so a byte that yields n
// units (n is 0 to 4) holds it until all are out, and input stalls only when
// the queue is full behind such a run or a stalled consumer. The replacement
// unit is written through the cfg channel, which is always ready; it should
// only be changed while no item is still on its way through the block.
module utf8_to_utf16_transcoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        end_of_string_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      code_unit_o,
  output logic             is_replacement_o,
  output logic             last_of_run_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);

  u2u_pkg::run_t      front_run;
  u2u_pkg::run_t      head_run;
  u2u_pkg::q_status_t q_status;
  logic               accept;
  logic               q_push;
  logic               q_pop;
  logic               out_valid;

  assign accept      = push && !q_status.full;
  assign full        = q_status.full;
  assign cfg_ready_o = 1'b1;

  u2u_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i        (accept),
    .in_byte_i,
    .end_of_string_i,
    .run_o           (front_run),
    .run_valid_o     (q_push)
  );

  u2u_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i   (q_push),
    .run_i    (front_run),
    .pop_i    (q_pop),
    .run_o    (head_run),
    .status_o (q_status)
  );

  u2u_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_valid_i      (cfg_valid_i && cfg_ready_o),
    .cfg_data_i,
    .run_i            (head_run),
    .run_avail_i      (!q_status.empty),
    .run_done_o       (q_pop),
    .out_valid_o      (out_valid),
    .out_pop_i        (pop),
    .code_unit_o,
    .is_replacement_o,
    .last_of_run_o
  );

  assign empty = !out_valid;

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_status.full)
    else $error("run queued while the queue is full");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_status.empty)
    else $error("run retired from an empty queue");

  a_run_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> ((front_run.n_repl + {1'b0, front_run.n_data}) != 3'd0)
               && ((front_run.n_repl + {1'b0, front_run.n_data}) <= 3'd4)
               && (front_run.n_data != 2'd3))
    else $error("queued run has an impossible number of units");

endmodule

`default_nettype wire

[test/utf8_to_utf16_transcoder_test.sv]
`timescale 1ns / 100ps

module utf8_to_utf16_transcoder_test;

  localparam int unsigned HalfPeriod  = 4;
  localparam int unsigned SettleTicks = 12;
  localparam int unsigned HoldTicks   = 300;
  localparam int unsigned PhaseBytes  = 120;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_repl;
    logic        last_unit;
  } unit_exp_t;

  class transcode_scoreboard;
    logic [15:0] repl_unit;
    logic [7:0]  lead;
    int unsigned held;
    int unsigned needed;
    logic [20:0] partial;
    unit_exp_t   run_units[$];
    unit_exp_t   expected_units[$];
    int unsigned errors;
    int unsigned bytes_noted;
    int unsigned units_checked;
    int unsigned repl_seen;
    int unsigned pairs_seen;

    function new();
      repl_unit     = u2u_pkg::ReplReset;
      errors        = 0;
      bytes_noted   = 0;
      units_checked = 0;
      repl_seen     = 0;
      pairs_seen    = 0;
      clear_seq();
    endfunction

    function void clear_seq();
      lead    = '0;
      held    = 0;
      needed  = 0;
      partial = '0;
    endfunction

    function void set_repl(logic [15:0] value);
      repl_unit = value;
    endfunction

    function int unsigned pending();
      return expected_units.size();
    endfunction

    function void add_unit(logic [15:0] code, logic r);
      unit_exp_t u;
      u.code_unit = code;
      u.is_repl   = r;
      u.last_unit = 1'b0;
      run_units.push_back(u);
    endfunction

    function void add_repl(int unsigned count);
      repeat (count) add_unit(repl_unit, 1'b1);
    endfunction

    function void commit();
      if (run_units.size() > 0) begin
        run_units[run_units.size() - 1].last_unit = 1'b1;
      end
      foreach (run_units[i]) expected_units.push_back(run_units[i]);
      run_units.delete();
    endfunction

    function bit cont_fits(logic [7:0] b);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = u2u_pkg::ContMin;
      hi = u2u_pkg::ContMax;
      if (held == 1) begin
        if (lead == u2u_pkg::Lead3Min) lo = u2u_pkg::ContE0Min;
        else if (lead == u2u_pkg::LeadSurr) hi = u2u_pkg::ContEdMax;
        else if (lead == u2u_pkg::Lead4Min) lo = u2u_pkg::ContF0Min;
        else if (lead == u2u_pkg::LeadMax) hi = u2u_pkg::ContF4Max;
      end
      return (b >= lo) && (b <= hi);
    endfunction

    function void note_byte(logic [7:0] b, logic eos);
      logic [20:0] scalar;
      logic [19:0] offset;
      bytes_noted++;
      run_units.delete();
      if (needed > 0) begin
        if (cont_fits(b)) begin
          partial = {partial[14:0], b[5:0]};
          held++;
          needed--;
          if (needed == 0) begin
            scalar = partial;
            if (scalar < u2u_pkg::SuppBase) begin
              add_unit(scalar[15:0], 1'b0);
            end else begin
              offset = 20'(scalar - u2u_pkg::SuppBase);
              add_unit(u2u_pkg::HighSurrBase + {6'b0, offset[19:10]}, 1'b0);
              add_unit(u2u_pkg::LowSurrBase + {6'b0, offset[9:0]}, 1'b0);
            end
            clear_seq();
          end else if (eos) begin
            add_repl(held);
            clear_seq();
          end
          commit();
          return;
        end
        add_repl(held);
        clear_seq();
      end
      if (b < u2u_pkg::AsciiLimit) begin
        add_unit({8'h00, b}, 1'b0);
      end else if (b >= u2u_pkg::LeadMin && b <= u2u_pkg::LeadMax) begin
        if (eos) begin
          add_repl(1);
        end else begin
          lead = b;
          held = 1;
          if (b < u2u_pkg::Lead3Min) begin
            needed  = 1;
            partial = {16'b0, b[4:0]};
          end else if (b < u2u_pkg::Lead4Min) begin
            needed  = 2;
            partial = {17'b0, b[3:0]};
          end else begin
            needed  = 3;
            partial = {18'b0, b[2:0]};
          end
        end
      end else begin
        add_repl(1);
      end
      commit();
    endfunction

    function void check_unit(logic [15:0] code, logic r, logic last_u);
      unit_exp_t want;
      units_checked++;
      if (expected_units.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unit %0d arrived with nothing expected: code %h repl %b last %b",
                   units_checked, code, r, last_u);
        end
        return;
      end
      want = expected_units.pop_front();
      if (want.code_unit !== code || want.is_repl !== r || want.last_unit !== last_u) begin
        errors++;
        if (errors <= 10) begin
          $display("unit %0d: expected code %h repl %b last %b, got code %h repl %b last %b",
                   units_checked, want.code_unit, want.is_repl, want.last_unit,
                   code, r, last_u);
        end
      end
      if (r) repl_seen++;
      if (!r && code >= u2u_pkg::HighSurrBase && code < u2u_pkg::LowSurrBase) pairs_seen++;
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  in_byte_i;
  logic        end_of_string_i;
  logic        empty;
  logic        pop;
  logic [15:0] code_unit_o;
  logic        is_replacement_o;
  logic        last_of_run_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;

  transcode_scoreboard score;
  bit          send_eager;
  bit          take_eager;
  bit          hold_req;
  int unsigned settings_used;
  logic [8:0]  byte_seq[$];

  utf8_to_utf16_transcoder u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .in_byte_i       (in_byte_i),
    .end_of_string_i (end_of_string_i),
    .empty           (empty),
    .pop             (pop),
    .code_unit_o     (code_unit_o),
    .is_replacement_o(is_replacement_o),
    .last_of_run_o   (last_of_run_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #(HalfPeriod) clk_i = ~clk_i;

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic eos);
    while (!send_eager && $urandom_range(99) < 32) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push            <= 1'b1;
    in_byte_i       <= b;
    end_of_string_i <= eos;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    score.note_byte(b, eos);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (score.pending() != 0) @(posedge clk_i);
    repeat (SettleTicks) @(posedge clk_i);
  endtask

  task automatic write_repl(input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    score.set_repl(value);
    settings_used++;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void encode_scalar(int unsigned s, int unsigned n);
    logic [20:0] v;
    v = 21'(s);
    byte_seq.delete();
    case (n)
      1: byte_seq.push_back({1'b0, 1'b0, v[6:0]});
      2: begin
        byte_seq.push_back({1'b0, 8'hC0 | {3'b0, v[10:6]}});
        byte_seq.push_back({1'b0, u2u_pkg::ContMin | {2'b0, v[5:0]}});
      end
      3: begin
        byte_seq.push_back({1'b0, u2u_pkg::Lead3Min | {4'b0, v[15:12]}});
        byte_seq.push_back({1'b0, u2u_pkg::ContMin | {2'b0, v[11:6]}});
        byte_seq.push_back({1'b0, u2u_pkg::ContMin | {2'b0, v[5:0]}});
      end
      default: begin
        byte_seq.push_back({1'b0, u2u_pkg::Lead4Min | {5'b0, v[20:18]}});
        byte_seq.push_back({1'b0, u2u_pkg::ContMin | {2'b0, v[17:12]}});
        byte_seq.push_back({1'b0, u2u_pkg::ContMin | {2'b0, v[11:6]}});
        byte_seq.push_back({1'b0, u2u_pkg::ContMin | {2'b0, v[5:0]}});
      end
    endcase
  endfunction

  function automatic int unsigned pick_scalar(int unsigned n);
    int unsigned s;
    bit          edge_pick;
    edge_pick = ($urandom_range(7) == 0);
    case (n)
      1: s = edge_pick ? 127 : $urandom_range(127, 0);
      2: s = edge_pick ? ($urandom_range(1) ? 'h80 : 'h7FF) : $urandom_range('h7FF, 'h80);
      3: begin
        if (edge_pick) begin
          case ($urandom_range(3))
            0: s = 'h800;
            1: s = 'hD7FF;
            2: s = 'hE000;
            default: s = 'hFFFF;
          endcase
        end else begin
          s = $urandom_range('hFFFF, 'h800);
          if (s >= 'hD800 && s <= 'hDFFF) s = s ^ 'h4000;
        end
      end
      default: s = edge_pick ? ($urandom_range(1) ? 'h10000 : 'h10FFFF)
                             : $urandom_range('h10FFFF, 'h10000);
    endcase
    return s;
  endfunction

  function automatic void make_sequence();
    int unsigned kind;
    int unsigned n;
    int unsigned pos;
    kind = $urandom_range(99);
    if (kind < 60) begin
      n = $urandom_range(4, 1);
      encode_scalar(pick_scalar(n), n);
      if ($urandom_range(5) == 0) byte_seq[byte_seq.size() - 1][8] = 1'b1;
    end else if (kind < 82) begin
      n = $urandom_range(4, 2);
      encode_scalar(pick_scalar(n), n);
      pos = $urandom_range(n - 1, 1);
      case ($urandom_range(2))
        0: byte_seq[pos] = {1'b0, 8'($urandom_range(255))};
        1: begin
          while (byte_seq.size() > pos) void'(byte_seq.pop_back());
          if ($urandom_range(1)) byte_seq[pos - 1][8] = 1'b1;
        end
        default: begin
          byte_seq[0] = {1'b0, 8'($urandom_range(255, 'hC0))};
          for (int i = 1; i < n; i++) byte_seq[i] = {1'b0, 8'($urandom_range('hBF, 'h80))};
        end
      endcase
    end else begin
      byte_seq.delete();
      n = $urandom_range(3, 1);
      repeat (n) byte_seq.push_back({1'($urandom_range(7) == 0), 8'($urandom_range(255))});
    end
  endfunction

  task automatic send_random(input int unsigned count, input int unsigned pause_at);
    int unsigned sent;
    bit          paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < count) begin
      make_sequence();
      foreach (byte_seq[i]) begin
        send_byte(byte_seq[i][7:0], byte_seq[i][8]);
        sent++;
      end
      if (!paused && pause_at != 0 && sent >= pause_at) begin
        paused = 1'b1;
        push <= 1'b0;
        while (score.pending() != 0) @(posedge clk_i);
      end
    end
  endtask

  initial begin : result_side
    int unsigned hold_left;
    bit          take;
    hold_left = 0;
    pop <= 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldTicks;
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else begin
        take = take_eager || ($urandom_range(99) >= 32);
      end
      pop <= take;
      @(posedge clk_i);
      if (pop && !empty) score.check_unit(code_unit_o, is_replacement_o, last_of_run_o);
    end
  end

  initial begin : stimulus
    logic [8:0] directed[$];
    score         = new();
    send_eager    = 1'b0;
    take_eager    = 1'b0;
    hold_req      = 1'b0;
    settings_used = 0;
    rst_ni          <= 1'b0;
    push            <= 1'b0;
    in_byte_i       <= '0;
    end_of_string_i <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_data_i      <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed = '{9'h000, 9'h17F, 9'h0DF, 9'h0BF, 9'h0ED, 9'h09F, 9'h0BF,
                 9'h0F4, 9'h08F, 9'h0BF, 9'h0BF, 9'h080, 9'h0FF,
                 9'h0E0, 9'h080, 9'h0ED, 9'h0A0, 9'h0F4, 9'h090,
                 9'h0F0, 9'h090, 9'h080, 9'h041,
                 9'h0E2, 9'h182, 9'h1C3,
                 9'h0F0, 9'h090, 9'h180};
    foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);

    drain();
    write_repl(16'h0000);
    send_eager = 1'b1;
    take_eager = 1'b1;
    send_random(100, 0);
    send_eager = 1'b0;
    take_eager = 1'b0;
    send_random(PhaseBytes - 100, 0);

    drain();
    write_repl(16'hFFFF);
    hold_req   = 1'b1;
    send_eager = 1'b1;
    send_random(40, 0);
    send_eager = 1'b0;
    send_random(PhaseBytes - 40, 0);

    drain();
    write_repl(16'($urandom_range(16'hFFFF)));
    send_random(PhaseBytes, PhaseBytes / 2);

    drain();
    write_repl(u2u_pkg::ReplReset);
    send_random(PhaseBytes, 0);

    drain();
    $display("Fed %0d bytes under %0d replacement settings; checked %0d units,",
             score.bytes_noted, settings_used + 1, score.units_checked);
    $display("of which %0d were replacements and %0d were surrogate pairs.",
             score.repl_seen, score.pairs_seen);
    if (score.errors == 0 && score.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
